### src/rsct_pkg.sv
// ----------------------------------------------------------------------------
// rsct_pkg
// Shared codes and helpers for the record stream collector tracker.
// ----------------------------------------------------------------------------
package rsct_pkg;

  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  localparam logic [1:0] INS_FLUSH   = 2'd0;
  localparam logic [1:0] INS_PROCESS = 2'd1;
  localparam logic [1:0] INS_IGNORE  = 2'd2;
  localparam logic [1:0] INS_REJECT  = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DUP_START = 3'd1;
  localparam logic [2:0] ERR_BAD_MID   = 3'd2;
  localparam logic [2:0] ERR_BAD_SEND  = 3'd3;
  localparam logic [2:0] ERR_BAD_POS   = 3'd4;
  localparam logic [2:0] ERR_BAD_UEND  = 3'd5;
  localparam logic [2:0] ERR_BAD_KIND  = 3'd6;
  localparam logic [2:0] ERR_FULL      = 3'd7;

  localparam logic [1:0] KIND_SNAP = 2'd0;
  localparam logic [1:0] KIND_UPD  = 2'd1;

  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_MID   = 2'd1;
  localparam logic [1:0] POS_END   = 2'd2;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

### src/rsct_front.sv
// ----------------------------------------------------------------------------
// rsct_front
// Accepts records, matches the key against the collector table and allocates
// a new slot in arrival order; pushes the classified record to the queue.
// ----------------------------------------------------------------------------
module rsct_front #(
  parameter int COLLECTORS = 16,
  parameter int TIME_WIDTH = 32,
  parameter int SW         = 4,
  parameter int QW         = 2 * 32 + 4 + 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_collector_key,
  input  logic [1:0]            in_dump_kind,
  input  logic [1:0]            in_record_position,
  input  logic [31:0]           in_dump_stamp,
  input  logic [31:0]           in_record_stamp,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [QW-1:0]         q_data
);

  localparam int UW = $clog2(COLLECTORS + 1);

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            pos;
    logic [TIME_WIDTH-1:0] dump;
    logic [TIME_WIDTH-1:0] rec;
    logic [SW-1:0]         slot;
    logic                  fresh;
    logic                  full;
  } q_item_t;

  logic [UW-1:0]         used_r;
  logic [UW-1:0]         used_nxt;
  logic [31:0]           keys_r [COLLECTORS];
  logic [COLLECTORS-1:0] hit;
  logic [SW-1:0]         hit_idx;
  logic                  found;
  logic                  full;
  logic                  accept;
  logic                  alloc;
  q_item_t               item;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < COLLECTORS; i++) begin
      hit[i] = (UW'(i) < used_r) && (keys_r[i] == in_collector_key);
      hit_idx = hit_idx | (hit[i] ? SW'(i) : '0);
    end
  end

  assign found    = |hit;
  assign full     = (used_r == UW'(COLLECTORS));
  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign alloc    = accept && !found && !full;
  assign used_nxt = alloc ? used_r + UW'(1) : used_r;

  always_comb begin
    item.kind  = in_dump_kind;
    item.pos   = in_record_position;
    item.dump  = TIME_WIDTH'(in_dump_stamp);
    item.rec   = TIME_WIDTH'(in_record_stamp);
    item.slot  = found ? hit_idx : used_r[SW-1:0];
    item.fresh = !found && !full;
    item.full  = !found && full;
  end

  assign q_valid = in_valid;
  assign q_data  = item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      keys_r[used_r[SW-1:0]] <= in_collector_key;
    end
  end

`ifndef SYNTHESIS
  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("collector key matches more than one slot");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(COLLECTORS))
    else $error("used slot count beyond table size");
`endif

endmodule

### src/rsct_fifo.sv
// ----------------------------------------------------------------------------
// rsct_fifo
// Two-entry queue between the classifying front and the slot update back.
// ----------------------------------------------------------------------------
module rsct_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int CW = $clog2(rsct_pkg::QDEPTH + 1);

  logic [WIDTH-1:0]       mem_r [rsct_pkg::QDEPTH];
  logic [rsct_pkg::QPW-1:0] wptr_r;
  logic [rsct_pkg::QPW-1:0] rptr_r;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;
  logic                   push;
  logic                   pop;

  assign wr_ready = (cnt_r != CW'(rsct_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + rsct_pkg::QPW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + rsct_pkg::QPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

### src/rsct_back.sv
// ----------------------------------------------------------------------------
// rsct_back
// Reads the slot state, applies the record rules, writes the state back and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module rsct_back #(
  parameter int COLLECTORS = 16,
  parameter int TIME_WIDTH = 32,
  parameter int SW         = 4,
  parameter int QW         = 2 * 32 + 4 + 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_instruction,
  output logic [2:0]    out_error_code,
  output logic [3:0]    out_slot,
  output logic          out_new_collector,
  output logic [31:0]   out_snapshots_count,
  output logic [31:0]   out_updates_count,
  output logic [31:0]   out_ignored_count
);

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            pos;
    logic [TIME_WIDTH-1:0] dump;
    logic [TIME_WIDTH-1:0] rec;
    logic [SW-1:0]         slot;
    logic                  fresh;
    logic                  full;
  } q_item_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]          snap_time;
    logic                           in_snap;
    logic [TIME_WIDTH-1:0]          lu_dump;
    logic [TIME_WIDTH-1:0]          lu_rec;
    logic [rsct_pkg::CNT_W-1:0]     snap_cnt;
    logic [rsct_pkg::CNT_W-1:0]     upd_cnt;
    logic [rsct_pkg::CNT_W-1:0]     ign_cnt;
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_EX   = 3'b100
  } state_t;

  state_t    state_r;
  state_t    state_nxt;
  q_item_t   item_r;
  slot_st_t  slot_mem [COLLECTORS];
  slot_st_t  rdata_r;
  slot_st_t  cur;
  slot_st_t  st_nxt;
  logic [1:0] ins_nxt;
  logic [2:0] err_nxt;
  logic       go;
  logic       pop;
  logic       wr_en;

  logic        out_valid_r;
  logic [1:0]  out_ins_r;
  logic [2:0]  out_err_r;
  logic [3:0]  out_slot_r;
  logic        out_new_r;
  logic [31:0] out_snap_r;
  logic [31:0] out_upd_r;
  logic [31:0] out_ign_r;

  assign go      = (state_r == ST_EX) && (!out_valid_r || out_ready);
  assign q_ready = (state_r == ST_IDLE) || go;
  assign pop     = q_valid && q_ready;
  assign wr_en   = go && !item_r.full;

  // slot state is cleared when the slot is allocated
  assign cur = item_r.fresh ? '0 : rdata_r;

  always_comb begin
    st_nxt  = cur;
    ins_nxt = rsct_pkg::INS_PROCESS;
    err_nxt = rsct_pkg::ERR_NONE;
    case (item_r.kind)
      rsct_pkg::KIND_SNAP: begin
        st_nxt.snap_cnt = rsct_pkg::sat_inc(cur.snap_cnt);
        case (item_r.pos)
          rsct_pkg::POS_START: begin
            if (cur.snap_time == '0 || cur.snap_time < item_r.dump) begin
              st_nxt           = '0;
              st_nxt.snap_time = item_r.dump;
              st_nxt.snap_cnt  = rsct_pkg::CNT_W'(1);
              st_nxt.in_snap   = 1'b1;
              ins_nxt          = rsct_pkg::INS_FLUSH;
            end else begin
              ins_nxt = rsct_pkg::INS_REJECT;
              err_nxt = rsct_pkg::ERR_DUP_START;
            end
          end
          rsct_pkg::POS_MID: begin
            if (cur.snap_time != item_r.dump) begin
              ins_nxt = rsct_pkg::INS_REJECT;
              err_nxt = rsct_pkg::ERR_BAD_MID;
            end
          end
          rsct_pkg::POS_END: begin
            if (cur.snap_time == item_r.dump) begin
              st_nxt.in_snap = 1'b0;
            end else begin
              ins_nxt = rsct_pkg::INS_REJECT;
              err_nxt = rsct_pkg::ERR_BAD_SEND;
            end
          end
          default: begin
            ins_nxt = rsct_pkg::INS_REJECT;
            err_nxt = rsct_pkg::ERR_BAD_POS;
          end
        endcase
      end
      rsct_pkg::KIND_UPD: begin
        if (cur.snap_time == '0 || cur.in_snap) begin
          st_nxt.ign_cnt = rsct_pkg::sat_inc(cur.ign_cnt);
          ins_nxt        = rsct_pkg::INS_IGNORE;
        end else begin
          st_nxt.upd_cnt = rsct_pkg::sat_inc(cur.upd_cnt);
          if (item_r.pos == rsct_pkg::POS_END && !(cur.lu_dump < item_r.dump)) begin
            ins_nxt = rsct_pkg::INS_REJECT;
            err_nxt = rsct_pkg::ERR_BAD_UEND;
          end else begin
            if (item_r.pos == rsct_pkg::POS_END) begin
              st_nxt.lu_dump = item_r.dump;
            end
            st_nxt.lu_rec = item_r.rec;
          end
        end
      end
      default: begin
        ins_nxt = rsct_pkg::INS_REJECT;
        err_nxt = rsct_pkg::ERR_BAD_KIND;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EX;
      end
      ST_EX: begin
        if (go) begin
          state_nxt = pop ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item_t'(q_data);
    end
    if (go) begin
      if (item_r.full) begin
        out_ins_r  <= rsct_pkg::INS_REJECT;
        out_err_r  <= rsct_pkg::ERR_FULL;
        out_slot_r <= '0;
        out_new_r  <= 1'b0;
        out_snap_r <= '0;
        out_upd_r  <= '0;
        out_ign_r  <= '0;
      end else begin
        out_ins_r  <= ins_nxt;
        out_err_r  <= err_nxt;
        out_slot_r <= 4'(item_r.slot);
        out_new_r  <= item_r.fresh;
        out_snap_r <= st_nxt.snap_cnt;
        out_upd_r  <= st_nxt.upd_cnt;
        out_ign_r  <= st_nxt.ign_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= slot_mem[item_r.slot];
    if (wr_en) begin
      slot_mem[item_r.slot] <= st_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_instruction     = out_ins_r;
  assign out_error_code      = out_err_r;
  assign out_slot            = out_slot_r;
  assign out_new_collector   = out_new_r;
  assign out_snapshots_count = out_snap_r;
  assign out_updates_count   = out_upd_r;
  assign out_ignored_count   = out_ign_r;

`ifndef SYNTHESIS
  a_rd_to_ex: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |=> state_r == ST_EX)
    else $error("slot read not followed by execute");

  a_err_matches_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_ins_r == rsct_pkg::INS_REJECT) ==
                     (out_err_r != rsct_pkg::ERR_NONE)))
    else $error("error code disagrees with instruction");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    go && item_r.full |=> out_err_r == rsct_pkg::ERR_FULL && out_slot_r == '0)
    else $error("table full record not rejected");
`endif

endmodule

### src/record_stream_collector_tracker.sv
// ----------------------------------------------------------------------------
// record_stream_collector_tracker
// Routing-dump record tracker: key lookup and slot allocation in front, a
// two-entry queue, then per-collector state update and result register.
// ----------------------------------------------------------------------------
// Path: an input beat is written into the queue, then into the back end item
// register; the slot state is read, then the result register is loaded.
// The back end takes no new record until it writes back the slot state of the
// last; the front keeps accepting into the queue meanwhile while it has room.
// Reset: synchronous, active low; clears the slot count, the queue, the back
// end state and the result valid. Slot state is cleared on allocation.
module record_stream_collector_tracker #(
  parameter int COLLECTORS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_collector_key,
  input  logic [1:0]  in_dump_kind,
  input  logic [1:0]  in_record_position,
  input  logic [31:0] in_dump_stamp,
  input  logic [31:0] in_record_stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_instruction,
  output logic [2:0]  out_error_code,
  output logic [3:0]  out_slot,
  output logic        out_new_collector,
  output logic [31:0] out_snapshots_count,
  output logic [31:0] out_updates_count,
  output logic [31:0] out_ignored_count
);

  localparam int SW = (COLLECTORS > 1) ? $clog2(COLLECTORS) : 1;
  localparam int QW = 2 * TIME_WIDTH + SW + 6;

  logic          fq_valid;
  logic          fq_ready;
  logic [QW-1:0] fq_data;
  logic          qb_valid;
  logic          qb_ready;
  logic [QW-1:0] qb_data;

  rsct_front #(
    .COLLECTORS(COLLECTORS),
    .TIME_WIDTH(TIME_WIDTH),
    .SW        (SW),
    .QW        (QW)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_collector_key  (in_collector_key),
    .in_dump_kind      (in_dump_kind),
    .in_record_position(in_record_position),
    .in_dump_stamp     (in_dump_stamp),
    .in_record_stamp   (in_record_stamp),
    .q_valid           (fq_valid),
    .q_ready           (fq_ready),
    .q_data            (fq_data)
  );

  rsct_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_data (fq_data),
    .rd_valid(qb_valid),
    .rd_ready(qb_ready),
    .rd_data (qb_data)
  );

  rsct_back #(
    .COLLECTORS(COLLECTORS),
    .TIME_WIDTH(TIME_WIDTH),
    .SW        (SW),
    .QW        (QW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (qb_valid),
    .q_ready            (qb_ready),
    .q_data             (qb_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_instruction    (out_instruction),
    .out_error_code     (out_error_code),
    .out_slot           (out_slot),
    .out_new_collector  (out_new_collector),
    .out_snapshots_count(out_snapshots_count),
    .out_updates_count  (out_updates_count),
    .out_ignored_count  (out_ignored_count)
  );

endmodule

### bench/record_stream_collector_tracker_tb.sv
// ----------------------------------------------------------------------------
// record_stream_collector_tracker_tb
// Self-checking bench: a directed table of routing-dump records and then
// random snapshot and update sequences with noise mixed in. Each result beat
// is checked against an in-bench collector table model. Both handshakes see
// random idling.
// ----------------------------------------------------------------------------
module record_stream_collector_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOL = 16;
  localparam int unsigned LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam logic [1:0] KIND_BAD2 = 2'd2;
  localparam logic [1:0] KIND_BAD3 = 2'd3;
  localparam logic [1:0] POS_BAD = 2'd3;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  kind;
    logic [1:0]  pos;
    logic [31:0] dump;
    logic [31:0] rstamp;
  } rec_t;

  typedef struct packed {
    logic [1:0]  ins;
    logic [2:0]  err;
    logic [3:0]  slot;
    logic        fresh;
    logic [31:0] snaps;
    logic [31:0] upds;
    logic [31:0] igns;
  } res_t;

  typedef struct packed {
    rec_t       r;
    bit         typed;
    logic [1:0] ins;
    logic [2:0] err;
  } row_t;

  typedef struct {
    res_t        res;
    int unsigned tag;
  } beat_t;

  // typed ins/err only where obvious; the rest comes from the collector model
  localparam row_t DIR [0:25] = '{
    '{'{32'h0000_0000, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'd100, 32'd1}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0000, rsct_pkg::KIND_SNAP, rsct_pkg::POS_MID, 32'd100, 32'd2}, 1'b0,
      rsct_pkg::INS_PROCESS, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0000, rsct_pkg::KIND_UPD, rsct_pkg::POS_MID, 32'd100, 32'd3}, 1'b1,
      rsct_pkg::INS_IGNORE, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0000, rsct_pkg::KIND_SNAP, rsct_pkg::POS_END, 32'd100, 32'd4}, 1'b1,
      rsct_pkg::INS_PROCESS, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0000, rsct_pkg::KIND_UPD, rsct_pkg::POS_END, 32'd50, 32'hFFFF_FFFF}, 1'b1,
      rsct_pkg::INS_PROCESS, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0000, rsct_pkg::KIND_UPD, rsct_pkg::POS_END, 32'd50, 32'd0}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_BAD_UEND},
    '{'{32'h0000_0000, rsct_pkg::KIND_UPD, POS_BAD, 32'd0, 32'd7}, 1'b0,
      rsct_pkg::INS_PROCESS, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0000, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'd100, 32'd8}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_DUP_START},
    '{'{32'h0000_0000, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'hFFFF_FFFF, 32'd9}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'hFFFF_FFFF, KIND_BAD2, rsct_pkg::POS_START, 32'd0, 32'd0}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_BAD_KIND},
    '{'{32'hFFFF_FFFF, rsct_pkg::KIND_UPD, rsct_pkg::POS_START, 32'd1, 32'd1}, 1'b1,
      rsct_pkg::INS_IGNORE, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0001, rsct_pkg::KIND_SNAP, rsct_pkg::POS_MID, 32'd5, 32'd5}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_BAD_MID},
    '{'{32'h8000_0000, rsct_pkg::KIND_SNAP, rsct_pkg::POS_END, 32'd7, 32'd6}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_BAD_SEND},
    '{'{32'h5555_5555, rsct_pkg::KIND_SNAP, POS_BAD, 32'd9, 32'd7}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_BAD_POS},
    '{'{32'hAAAA_AAAA, KIND_BAD3, POS_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_BAD_KIND},
    '{'{32'h0000_0100, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'd0, 32'h8000_0000}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'h1234_5678, rsct_pkg::KIND_UPD, rsct_pkg::POS_END, 32'd10, 32'h5555_5555}, 1'b1,
      rsct_pkg::INS_IGNORE, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0010, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'd1, 32'hAAAA_AAAA}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'h0000_0011, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'd2, 32'd11}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'h7FFF_FFFF, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'd1000, 32'd12}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'hFFFF_FFFE, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'h0001_0000, 32'd13}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'h0F0F_0F0F, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'h7FFF_0000, 32'd14}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'hF0F0_F0F0, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'h8000_0000, 32'd15}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'h3333_3333, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'hC000_0000, 32'd16}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'hCCCC_CCCC, rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, 32'hFFFF_0000, 32'd17}, 1'b1,
      rsct_pkg::INS_FLUSH, rsct_pkg::ERR_NONE},
    '{'{32'hFEED_0001, rsct_pkg::KIND_UPD, rsct_pkg::POS_END, 32'd20, 32'd18}, 1'b1,
      rsct_pkg::INS_REJECT, rsct_pkg::ERR_FULL}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_collector_key;
  logic [1:0]  in_dump_kind;
  logic [1:0]  in_record_position;
  logic [31:0] in_dump_stamp;
  logic [31:0] in_record_stamp;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_instruction;
  logic [2:0]  out_error_code;
  logic [3:0]  out_slot;
  logic        out_new_collector;
  logic [31:0] out_snapshots_count;
  logic [31:0] out_updates_count;
  logic [31:0] out_ignored_count;

  record_stream_collector_tracker dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_collector_key    (in_collector_key),
    .in_dump_kind        (in_dump_kind),
    .in_record_position  (in_record_position),
    .in_dump_stamp       (in_dump_stamp),
    .in_record_stamp     (in_record_stamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_instruction     (out_instruction),
    .out_error_code      (out_error_code),
    .out_slot            (out_slot),
    .out_new_collector   (out_new_collector),
    .out_snapshots_count (out_snapshots_count),
    .out_updates_count   (out_updates_count),
    .out_ignored_count   (out_ignored_count)
  );

  // collector table model
  int          n_used = 0;
  logic [31:0] col_key     [NCOL];
  logic [31:0] snap_at     [NCOL];
  logic        snap_open   [NCOL];
  logic [31:0] upd_dump_at [NCOL];
  logic [31:0] upd_rec_at  [NCOL];
  logic [31:0] n_snap      [NCOL];
  logic [31:0] n_upd       [NCOL];
  logic [31:0] n_ign       [NCOL];

  beat_t       pending_results [$];
  int unsigned cyc = 0;
  int unsigned errs = 0;
  int unsigned n_items = 0;
  bit          calm = 1'b0;
  res_t        seen;
  beat_t       head;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void wipe(input int s);
    snap_at[s] = '0;
    snap_open[s] = 1'b0;
    upd_dump_at[s] = '0;
    upd_rec_at[s] = '0;
    n_snap[s] = '0;
    n_upd[s] = '0;
    n_ign[s] = '0;
  endfunction

  function automatic res_t track_record(input rec_t r);
    res_t o;
    int   s;
    bit   hit;
    o = '0;
    s = 0;
    hit = 1'b0;
    for (int i = 0; i < n_used; i++) begin
      if (!hit && col_key[i] == r.key) begin
        s = i;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (n_used >= NCOL) begin
        o.ins = rsct_pkg::INS_REJECT;
        o.err = rsct_pkg::ERR_FULL;
        return o;
      end
      s = n_used;
      col_key[s] = r.key;
      wipe(s);
      n_used++;
      o.fresh = 1'b1;
    end
    o.slot = 4'(s);
    o.err = rsct_pkg::ERR_NONE;
    o.ins = rsct_pkg::INS_PROCESS;
    case (r.kind)
      rsct_pkg::KIND_SNAP: begin
        n_snap[s] = bump(n_snap[s]);
        case (r.pos)
          rsct_pkg::POS_START: begin
            if (snap_at[s] == '0 || snap_at[s] < r.dump) begin
              wipe(s);
              snap_at[s] = r.dump;
              n_snap[s] = 32'd1;
              snap_open[s] = 1'b1;
              o.ins = rsct_pkg::INS_FLUSH;
            end else begin
              o.ins = rsct_pkg::INS_REJECT;
              o.err = rsct_pkg::ERR_DUP_START;
            end
          end
          rsct_pkg::POS_MID: begin
            if (snap_at[s] != r.dump) begin
              o.ins = rsct_pkg::INS_REJECT;
              o.err = rsct_pkg::ERR_BAD_MID;
            end
          end
          rsct_pkg::POS_END: begin
            if (snap_at[s] == r.dump) begin
              snap_open[s] = 1'b0;
            end else begin
              o.ins = rsct_pkg::INS_REJECT;
              o.err = rsct_pkg::ERR_BAD_SEND;
            end
          end
          default: begin
            o.ins = rsct_pkg::INS_REJECT;
            o.err = rsct_pkg::ERR_BAD_POS;
          end
        endcase
      end
      rsct_pkg::KIND_UPD: begin
        if (snap_at[s] == '0 || snap_open[s]) begin
          n_ign[s] = bump(n_ign[s]);
          o.ins = rsct_pkg::INS_IGNORE;
        end else begin
          n_upd[s] = bump(n_upd[s]);
          if (r.pos == rsct_pkg::POS_END && upd_dump_at[s] >= r.dump) begin
            o.ins = rsct_pkg::INS_REJECT;
            o.err = rsct_pkg::ERR_BAD_UEND;
          end else begin
            if (r.pos == rsct_pkg::POS_END) upd_dump_at[s] = r.dump;
            upd_rec_at[s] = r.rstamp;
          end
        end
      end
      default: begin
        o.ins = rsct_pkg::INS_REJECT;
        o.err = rsct_pkg::ERR_BAD_KIND;
      end
    endcase
    o.snaps = n_snap[s];
    o.upds = n_upd[s];
    o.igns = n_ign[s];
    return o;
  endfunction

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send(input rec_t r, input bit typed, input logic [1:0] t_ins,
                      input logic [2:0] t_err);
    res_t e;
    in_valid <= 1'b1;
    in_collector_key <= r.key;
    in_dump_kind <= r.kind;
    in_record_position <= r.pos;
    in_dump_stamp <= r.dump;
    in_record_stamp <= r.rstamp;
    do @(posedge clk); while (!in_ready);
    e = track_record(r);
    if (typed) begin
      e.ins = t_ins;
      e.err = t_err;
    end
    pending_results.push_back('{e, cyc});
    n_items++;
    calm <= (n_items >= 450 && n_items < 600);
  endtask

  task automatic emit(input logic [31:0] key, input logic [1:0] kind,
                      input logic [1:0] pos, input logic [31:0] dump);
    rec_t r;
    r = '{key, kind, pos, dump, $urandom};
    // occasional corruption to break a sequence
    if ($urandom_range(0, 11) == 0) r.dump ^= 32'd1 << $urandom_range(0, 31);
    if ($urandom_range(0, 15) == 0) r.pos = 2'($urandom_range(0, 3));
    maybe_gap();
    send(r, 1'b0, rsct_pkg::INS_PROCESS, rsct_pkg::ERR_NONE);
  endtask

  task automatic random_burst();
    int          pick;
    int          s;
    logic [31:0] d;
    logic [1:0]  p;
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, n_used - 1);
    if (pick < 65 && snap_at[s] < 32'hFFF0_0000) begin
      d = snap_at[s] + $urandom_range(1, ($urandom_range(0, 3) == 0) ? 32'h000F_FFFF : 16);
      emit(col_key[s], rsct_pkg::KIND_SNAP, rsct_pkg::POS_START, d);
      repeat ($urandom_range(0, 3))
        emit(col_key[s], ($urandom_range(0, 4) == 0) ? rsct_pkg::KIND_UPD : rsct_pkg::KIND_SNAP,
             rsct_pkg::POS_MID, d);
      emit(col_key[s], rsct_pkg::KIND_SNAP, rsct_pkg::POS_END, d);
      repeat ($urandom_range(1, 5)) begin
        p = ($urandom_range(0, 1) == 0) ? rsct_pkg::POS_END : 2'($urandom_range(0, 3));
        d = ($urandom_range(0, 7) == 0) ? $urandom
                                        : upd_dump_at[s] + $urandom_range(0, 5000);
        emit(col_key[s], rsct_pkg::KIND_UPD, p, d);
      end
    end else if (pick < 95) begin
      emit(col_key[s], 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
    end else begin
      emit($urandom, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("FAIL record_stream_collector_tracker");
      $finish;
    end
  end

  // an expectation pushed in this very step cannot yet have a result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_instruction, out_error_code, out_slot, out_new_collector,
               out_snapshots_count, out_updates_count, out_ignored_count};
      if (pending_results.size() == 0 || pending_results[0].tag == cyc) begin
        errs++;
        $display("%0t: unexpected beat, expected none, got ins=%0d err=%0d slot=%0d",
                 $time, seen.ins, seen.err, seen.slot);
      end else begin
        head = pending_results.pop_front();
        if (seen !== head.res) begin
          errs++;
          $display({"%0t: mismatch expected ins=%0d err=%0d slot=%0d new=%0b",
                    " snap=%0d upd=%0d ign=%0d"},
                   $time, head.res.ins, head.res.err, head.res.slot, head.res.fresh,
                   head.res.snaps, head.res.upds, head.res.igns);
          $display({"%0t:          actual   ins=%0d err=%0d slot=%0d new=%0b",
                    " snap=%0d upd=%0d ign=%0d"},
                   $time, seen.ins, seen.err, seen.slot, seen.fresh,
                   seen.snaps, seen.upds, seen.igns);
        end
      end
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_collector_key <= '0;
    in_dump_kind <= rsct_pkg::KIND_SNAP;
    in_record_position <= rsct_pkg::POS_START;
    in_dump_stamp <= '0;
    in_record_stamp <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR[i]) begin
      maybe_gap();
      send(DIR[i].r, DIR[i].typed, DIR[i].ins, DIR[i].err);
    end

    // hold the sender until the pipeline has emptied
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      random_burst();
      if (!drained && n_items >= 700) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (12) @(posedge clk);
    if (errs == 0)
      $display("PASS record_stream_collector_tracker");
    else
      $display("FAIL record_stream_collector_tracker");
    $finish;
  end

endmodule

### files.f
src/rsct_pkg.sv
src/rsct_front.sv
src/rsct_fifo.sv
src/rsct_back.sv
src/record_stream_collector_tracker.sv
bench/record_stream_collector_tracker_tb.sv
